// ----- rtl/mpcs_pkg.sv -----
// Shared types and constants for the maximin palette color select unit.
`default_nettype none

package mpcs_pkg;

  // Widths of one color and of one squared distance
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SQ_W    = 16;
  localparam int unsigned DIST_W  = 18;

  // Operation codes carried on s_tuser
  localparam logic [1:0] OP_ADD_PALETTE = 2'd0;
  localparam logic [1:0] OP_ADD_IN_USE  = 2'd1;
  localparam logic [1:0] OP_CHOOSE      = 2'd2;

  // Distance reported when no in-use colors are held
  localparam logic [DIST_W-1:0] DIST_NONE = '1;
  // Largest distance two 8-bit RGB colors can have (3 * 255 * 255)
  localparam logic [DIST_W-1:0] DIST_MAX  = 18'd195075;

  // Per-pair tag that travels alongside the distance pipeline
  typedef struct packed {
    logic valid;       // a palette / in-use pair is in this stage
    logic first;       // first in-use color of a palette row
    logic last;        // last in-use color of a palette row
    logic final_pair;  // last pair of the whole search
    logic no_use;      // in-use store empty: distance is DIST_NONE
  } pair_tag_t;

endpackage

`default_nettype wire

// ----- rtl/mpcs_dist.sv -----
// Squared RGB distance unit: registered channel squares, then one 3-way sum.
`default_nettype none

module mpcs_dist (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mpcs_pkg::pair_tag_t           in_tag,
  input  wire logic [mpcs_pkg::COLOR_W-1:0]  pal_color,
  input  wire logic [mpcs_pkg::COLOR_W-1:0]  use_color,
  output mpcs_pkg::pair_tag_t                out_tag,
  output logic [mpcs_pkg::COLOR_W-1:0]       out_pal,
  output logic [mpcs_pkg::DIST_W-1:0]        sq_sum
);

  logic [mpcs_pkg::SQ_W-1:0] sq_next [3];
  logic [mpcs_pkg::SQ_W-1:0] sq      [3];

  // Absolute channel difference and its square
  always_comb begin
    logic [mpcs_pkg::CHAN_W-1:0] x;
    logic [mpcs_pkg::CHAN_W-1:0] y;
    logic [mpcs_pkg::CHAN_W-1:0] d;
    for (int c = 0; c < 3; c++) begin
      x = pal_color[c*mpcs_pkg::CHAN_W +: mpcs_pkg::CHAN_W];
      y = use_color[c*mpcs_pkg::CHAN_W +: mpcs_pkg::CHAN_W];
      d = (x > y) ? (x - y) : (y - x);
      sq_next[c] = mpcs_pkg::SQ_W'(d) * mpcs_pkg::SQ_W'(d);
    end
  end

  // Square register stage with its tag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else begin
      out_tag <= in_tag;
    end
    sq      <= sq_next;
    out_pal <= pal_color;
  end

  // Sum of the three squares
  assign sq_sum = mpcs_pkg::DIST_W'(sq[0]) + mpcs_pkg::DIST_W'(sq[1])
                + mpcs_pkg::DIST_W'(sq[2]);

endmodule

`default_nettype wire

// ----- rtl/maximin_palette_color_select_unit.sv -----
// Maximin palette color select: top level with color stores and search sequencer.
//
//  channel | dir | tdata (low bit up)                               | tuser
//  s_*     | in  | red[7:0] green[15:8] blue[23:16]                 | op[1:0]
//  m_*     | out | chosen_red[7:0] chosen_green[15:8]               | found[0]
//          |     | chosen_blue[23:16] min_distance[41:24]           |
//          |     | overflowed[42], zero pad [47:43]                 |
//
// Color loads are taken back to back.
// A choose holds the input until its result is registered. The search walks
// each palette color against every in-use color (one pair when none are
// held), one pair per cycle through the single distance unit, behind the
// registered store reads; an empty palette is answered without a search.
// Reset clears the counts, the overflow flag and the output valid flag; the
// stores themselves are not cleared.
// A pending output does not block loads; a choose waits to start its search
// until the output register is free.
`default_nettype none

module maximin_palette_color_select_unit #(
  parameter int unsigned PALETTE_DEPTH = 64,
  parameter int unsigned IN_USE_DEPTH  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // red[7:0] green[15:8] blue[23:16]
  input  wire logic [1:0]  s_tuser,   // op[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // chosen_red, chosen_green, chosen_blue,
                                      // min_distance[41:24], overflowed[42]
  output logic             m_tuser    // found[0]
);

  localparam int unsigned PCW = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned UCW = $clog2(IN_USE_DEPTH + 1);
  localparam int unsigned PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned UAW = (IN_USE_DEPTH > 1) ? $clog2(IN_USE_DEPTH) : 1;

  localparam int unsigned CW = mpcs_pkg::COLOR_W;
  localparam int unsigned DW = mpcs_pkg::DIST_W;

  typedef enum logic [1:0] {
    IDLE,
    START,
    RUN,
    DRAIN
  } state_t;

  state_t state;

  // Color stores
  logic [CW-1:0] pal_mem [PALETTE_DEPTH];
  logic [CW-1:0] use_mem [IN_USE_DEPTH];
  logic [CW-1:0] pal_q;
  logic [CW-1:0] use_q;

  logic [PCW-1:0] pal_cnt;
  logic [UCW-1:0] use_cnt;
  logic           ovf;

  logic [PAW-1:0] p_idx;
  logic [UAW-1:0] a_idx;

  // Output register
  logic           out_valid;
  logic [CW-1:0]  out_color;
  logic [DW-1:0]  out_dist;
  logic           out_found;
  logic           out_ovf;

  // Running search results
  logic           have;
  logic [CW-1:0]  lead_color;
  logic [DW-1:0]  best_dist;
  logic [DW-1:0]  row_min_q;

  logic in_xfer;
  logic out_xfer;
  logic pal_room;
  logic use_room;
  logic out_free;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign s_tready = (state == IDLE);
  assign pal_room = (pal_cnt < PCW'(PALETTE_DEPTH));
  assign use_room = (use_cnt < UCW'(IN_USE_DEPTH));
  assign out_free = !out_valid || m_tready;

  // Last indices of the walk
  logic [PCW-1:0] pal_m1;
  logic [UCW-1:0] use_m1;
  logic [PAW-1:0] p_last;
  logic [UAW-1:0] a_last;

  assign pal_m1 = pal_cnt - PCW'(1);
  assign use_m1 = use_cnt - UCW'(1);
  assign p_last = pal_m1[PAW-1:0];
  assign a_last = (use_cnt == '0) ? '0 : use_m1[UAW-1:0];

  // Issue-stage tag
  mpcs_pkg::pair_tag_t tag0;
  mpcs_pkg::pair_tag_t tag1;
  mpcs_pkg::pair_tag_t tag2;

  always_comb begin
    tag0.valid      = (state == RUN);
    tag0.first      = (a_idx == '0);
    tag0.last       = (a_idx == a_last);
    tag0.final_pair = (a_idx == a_last) && (p_idx == p_last);
    tag0.no_use     = (use_cnt == '0);
  end

  // Store writes and registered reads
  always_ff @(posedge clk) begin
    if (in_xfer && (s_tuser == mpcs_pkg::OP_ADD_PALETTE) && pal_room) begin
      pal_mem[pal_cnt[PAW-1:0]] <= s_tdata;
    end
    if (in_xfer && (s_tuser == mpcs_pkg::OP_ADD_IN_USE) && use_room) begin
      use_mem[use_cnt[UAW-1:0]] <= s_tdata;
    end
    pal_q <= pal_mem[p_idx];
    use_q <= use_mem[a_idx];
  end

  // Tag aligned with the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else begin
      tag1 <= tag0;
    end
  end

  // Shared distance unit
  logic [CW-1:0] pal2;
  logic [DW-1:0] dist2;

  mpcs_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_tag    (tag1),
    .pal_color (pal_q),
    .use_color (use_q),
    .out_tag   (tag2),
    .out_pal   (pal2),
    .sq_sum    (dist2)
  );

  // Row minimum and maximin compare
  logic [DW-1:0] d_eff;
  logic [DW-1:0] row_min;
  logic          take;
  logic [CW-1:0] lead_color_eff;
  logic [DW-1:0] best_dist_eff;

  always_comb begin
    d_eff          = tag2.no_use ? mpcs_pkg::DIST_NONE : dist2;
    row_min        = (tag2.first || (d_eff < row_min_q)) ? d_eff : row_min_q;
    take           = tag2.valid && tag2.last && (!have || (row_min > best_dist));
    lead_color_eff = take ? pal2 : lead_color;
    best_dist_eff  = take ? row_min : best_dist;
  end

  always_ff @(posedge clk) begin
    if (tag2.valid) begin
      row_min_q <= row_min;
    end
    if (take) begin
      lead_color <= pal2;
      best_dist  <= row_min;
    end
  end

  // Sequencer, counts and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      pal_cnt   <= '0;
      use_cnt   <= '0;
      ovf       <= 1'b0;
      have      <= 1'b0;
      out_valid <= 1'b0;
      p_idx     <= '0;
      a_idx     <= '0;
    end else begin
      if (out_xfer) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        have <= 1'b1;
      end
      unique case (state)
        IDLE: begin
          if (in_xfer) begin
            unique case (s_tuser)
              mpcs_pkg::OP_ADD_PALETTE: begin
                if (pal_room) begin
                  pal_cnt <= pal_cnt + PCW'(1);
                end else begin
                  ovf <= 1'b1;
                end
              end
              mpcs_pkg::OP_ADD_IN_USE: begin
                if (use_room) begin
                  use_cnt <= use_cnt + UCW'(1);
                end else begin
                  ovf <= 1'b1;
                end
              end
              mpcs_pkg::OP_CHOOSE: begin
                state <= START;
              end
              default: begin
              end
            endcase
          end
        end
        START: begin
          if (out_free) begin
            if (pal_cnt == '0) begin
              // empty palette: answer at once
              out_valid <= 1'b1;
              out_color <= '0;
              out_dist  <= '0;
              out_found <= 1'b0;
              out_ovf   <= ovf;
              use_cnt   <= '0;
              ovf       <= 1'b0;
              state     <= IDLE;
            end else begin
              have  <= 1'b0;
              p_idx <= '0;
              a_idx <= '0;
              state <= RUN;
            end
          end
        end
        RUN: begin
          if (tag0.last) begin
            a_idx <= '0;
            if (tag0.final_pair) begin
              state <= DRAIN;
            end else begin
              p_idx <= p_idx + PAW'(1);
            end
          end else begin
            a_idx <= a_idx + UAW'(1);
          end
        end
        DRAIN: begin
          if (tag2.valid && tag2.final_pair) begin
            out_valid <= 1'b1;
            out_color <= lead_color_eff;
            out_dist  <= best_dist_eff;
            out_found <= 1'b1;
            out_ovf   <= ovf;
            pal_cnt   <= '0;
            use_cnt   <= '0;
            ovf       <= 1'b0;
            p_idx     <= '0;
            state     <= IDLE;
          end
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_ovf, out_dist, out_color};
  assign m_tuser  = out_found;

endmodule

`default_nettype wire

// ----- rtl/mpcs_check.sv -----
// Port-level checks for the maximin palette color select unit, with its bind.
`default_nettype none

module mpcs_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [23:0] s_tdata,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        m_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // No result comes out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A choose closes the input once it is taken
  a_choose_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == mpcs_pkg::OP_CHOOSE) |=> !s_tready)
    else $error("input taken right after a choose");

  // Not-found result carries zero color and distance
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[41:0] == 42'd0))
    else $error("not-found result with nonzero payload");

  // Distance is a real squared distance or the no-in-use ceiling
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[41:24] <= mpcs_pkg::DIST_MAX)
              || (m_tdata[41:24] == mpcs_pkg::DIST_NONE))
    else $error("distance out of range");

endmodule

bind maximin_palette_color_select_unit mpcs_check u_mpcs_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
